@@ rtl/pac_pkg.sv @@
// ----------------------------------------------------------------------------
// pac_pkg
// Shared types, codes and sizes for the paired address cache.
// ----------------------------------------------------------------------------
package pac_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_W        = 48;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Function codes of an input beat.
    typedef enum logic [1:0] {
        FUNC_QUERY     = 2'd0,
        FUNC_REFRESH   = 2'd1,
        FUNC_LOAD      = 2'd2,
        FUNC_FETCH_END = 2'd3
    } pac_func_t;

    // Validity state of the cached list.
    typedef enum logic [1:0] {
        STATUS_OUTSTANDING = 2'd0,
        STATUS_FAILED      = 2'd1,
        STATUS_VALID       = 2'd2
    } pac_status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EXEC = 2'd2,
        ST_OUT  = 2'd3
    } pac_state_t;

    // Query answers.
    localparam logic [1:0] ANS_NOT_PAIRED = 2'd0;
    localparam logic [1:0] ANS_PAIRED     = 2'd1;
    localparam logic [1:0] ANS_DEFERRED   = 2'd2;

    // Notification error codes.
    localparam logic [1:0] NERR_NONE         = 2'd0;
    localparam logic [1:0] NERR_TABLE_FULL   = 2'd1;
    localparam logic [1:0] NERR_FETCH_FAILED = 2'd2;

    // Fetch outcome at or above this value counts as a failure.
    localparam logic [1:0] OUTCOME_FAILURE = 2'd2;

endpackage

@@ rtl/pac_ram.sv @@
// ----------------------------------------------------------------------------
// pac_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module pac_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/paired_address_cache.sv @@
// ----------------------------------------------------------------------------
// paired_address_cache
// Table of paired device addresses with a validity state and fetch control.
// ----------------------------------------------------------------------------
// One beat is handled at a time; s_ready is high only while the block is
// idle. A query, or a load that may still be added while an update is
// outstanding, scans the stored entries through the single read port of the
// address memory, one entry per cycle with registered read data, stopping
// early on a match; after the scan the beat is applied in the execute state.
// A refresh, a fetch-end notice or a load that needs no search goes straight
// to the execute state. That state loads the output register and raises
// m_valid. The result then waits in the output register until taken, and the
// next beat can be accepted in the cycle after that. The table needs no
// clearing pass: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module paired_address_cache (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_func,
    input  logic [pac_pkg::ADDR_W-1:0] s_address,
    input  logic                      s_last,
    input  logic [1:0]                s_fetch_outcome,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_answer,
    output logic                      m_retrieve_request,
    output logic                      m_notify,
    output logic [1:0]                m_notify_error
);

    // Sequencer and cache state.
    pac_pkg::pac_state_t  state_reg, state_next;
    pac_pkg::pac_status_t status_reg, status_next;
    logic [pac_pkg::CNT_W-1:0] count_reg, count_next;
    logic [pac_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic deferred_reg, deferred_next;
    logic load_failed_reg, load_failed_next;
    logic cmp_pend_reg, cmp_pend_next;
    logic found_reg, found_next;

    // Captured input beat.
    pac_pkg::pac_func_t        func_reg, func_next;
    logic [pac_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                      last_reg, last_next;
    logic [1:0]                outcome_reg, outcome_next;

    // Output register.
    logic       m_valid_reg, m_valid_next;
    logic [1:0] answer_reg, answer_next;
    logic       retrieve_reg, retrieve_next;
    logic       notify_reg, notify_next;
    logic [1:0] nerr_reg, nerr_next;

    // Memory ports.
    logic                       rd_en;
    logic [pac_pkg::ADDR_W-1:0] rd_data;
    logic                       wr_en;
    logic                       accept;
    logic                       need_scan;
    logic                       lf_v;
    logic [1:0]                 ans_v;
    logic [1:0]                 err_v;

    pac_ram #(
        .DEPTH (pac_pkg::TABLE_ENTRIES),
        .WIDTH (pac_pkg::ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[pac_pkg::IDX_W-1:0]),
        .wr_data (addr_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[pac_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign s_ready            = (state_reg == pac_pkg::ST_IDLE);
    assign accept             = s_valid && s_ready;
    assign m_valid            = m_valid_reg;
    assign m_answer           = answer_reg;
    assign m_retrieve_request = retrieve_reg;
    assign m_notify           = notify_reg;
    assign m_notify_error     = nerr_reg;

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= pac_pkg::ST_IDLE;
            status_reg      <= pac_pkg::STATUS_OUTSTANDING;
            count_reg       <= '0;
            idx_reg         <= '0;
            deferred_reg    <= 1'b0;
            load_failed_reg <= 1'b0;
            cmp_pend_reg    <= 1'b0;
            found_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            status_reg      <= status_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            deferred_reg    <= deferred_next;
            load_failed_reg <= load_failed_next;
            cmp_pend_reg    <= cmp_pend_next;
            found_reg       <= found_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        addr_reg     <= addr_next;
        last_reg     <= last_next;
        outcome_reg  <= outcome_next;
        answer_reg   <= answer_next;
        retrieve_reg <= retrieve_next;
        notify_reg   <= notify_next;
        nerr_reg     <= nerr_next;
    end

    // Next state and datapath control.
    always_comb begin
        state_next       = state_reg;
        status_next      = status_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        deferred_next    = deferred_reg;
        load_failed_next = load_failed_reg;
        cmp_pend_next    = 1'b0;
        found_next       = found_reg;
        func_next        = func_reg;
        addr_next        = addr_reg;
        last_next        = last_reg;
        outcome_next     = outcome_reg;
        m_valid_next     = m_valid_reg;
        answer_next      = answer_reg;
        retrieve_next    = retrieve_reg;
        notify_next      = notify_reg;
        nerr_next        = nerr_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        need_scan        = 1'b0;
        lf_v             = load_failed_reg;
        ans_v            = pac_pkg::ANS_NOT_PAIRED;
        err_v            = pac_pkg::NERR_NONE;

        case (state_reg)
            // Capture a beat and decide whether the table must be searched.
            pac_pkg::ST_IDLE: begin
                if (accept) begin
                    func_next    = pac_pkg::pac_func_t'(s_func);
                    addr_next    = s_address;
                    last_next    = s_last;
                    outcome_next = s_fetch_outcome;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    need_scan    = (s_func == pac_pkg::FUNC_QUERY) ||
                                   ((s_func == pac_pkg::FUNC_LOAD) &&
                                    (status_reg == pac_pkg::STATUS_OUTSTANDING) &&
                                    !load_failed_reg);
                    state_next   = need_scan ? pac_pkg::ST_SCAN : pac_pkg::ST_EXEC;
                end
            end

            // Read one entry per cycle and compare the entry read last cycle.
            pac_pkg::ST_SCAN: begin
                rd_en         = (idx_reg < count_reg);
                cmp_pend_next = rd_en;
                found_next    = found_reg || (cmp_pend_reg && (rd_data == addr_reg));
                if (rd_en) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (found_next || (!rd_en && !cmp_pend_reg)) begin
                    state_next = pac_pkg::ST_EXEC;
                end
            end

            // Apply the beat to the cache state and form the result.
            pac_pkg::ST_EXEC: begin
                retrieve_next = 1'b0;
                notify_next   = 1'b0;
                nerr_next     = pac_pkg::NERR_NONE;
                case (func_reg)
                    pac_pkg::FUNC_QUERY: begin
                        if (status_reg == pac_pkg::STATUS_OUTSTANDING) begin
                            ans_v = pac_pkg::ANS_DEFERRED;
                        end else if (status_reg == pac_pkg::STATUS_FAILED) begin
                            count_next       = '0;
                            load_failed_next = 1'b0;
                            status_next      = pac_pkg::STATUS_OUTSTANDING;
                            retrieve_next    = 1'b1;
                            ans_v            = pac_pkg::ANS_DEFERRED;
                        end
                        if (found_reg) begin
                            ans_v = pac_pkg::ANS_PAIRED;
                        end
                        if (ans_v == pac_pkg::ANS_DEFERRED) begin
                            deferred_next = 1'b1;
                        end
                    end
                    pac_pkg::FUNC_REFRESH: begin
                        count_next       = '0;
                        load_failed_next = 1'b0;
                        status_next      = pac_pkg::STATUS_OUTSTANDING;
                        retrieve_next    = 1'b1;
                    end
                    pac_pkg::FUNC_LOAD: begin
                        if (status_reg == pac_pkg::STATUS_OUTSTANDING) begin
                            if (!load_failed_reg && !found_reg) begin
                                if (count_reg <
                                    pac_pkg::CNT_W'(pac_pkg::TABLE_ENTRIES)) begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end else begin
                                    lf_v = 1'b1;
                                end
                            end
                            load_failed_next = lf_v;
                            if (last_reg) begin
                                err_v = lf_v ? pac_pkg::NERR_TABLE_FULL
                                             : pac_pkg::NERR_NONE;
                            end
                        end
                    end
                    pac_pkg::FUNC_FETCH_END: begin
                        if (status_reg == pac_pkg::STATUS_OUTSTANDING) begin
                            err_v = (outcome_reg >= pac_pkg::OUTCOME_FAILURE)
                                    ? pac_pkg::NERR_FETCH_FAILED : pac_pkg::NERR_NONE;
                        end
                    end
                    default: begin
                    end
                endcase

                // Resolution of the outstanding update.
                if ((status_reg == pac_pkg::STATUS_OUTSTANDING) &&
                    (((func_reg == pac_pkg::FUNC_LOAD) && last_reg) ||
                     (func_reg == pac_pkg::FUNC_FETCH_END))) begin
                    status_next      = (err_v != pac_pkg::NERR_NONE)
                                       ? pac_pkg::STATUS_FAILED : pac_pkg::STATUS_VALID;
                    load_failed_next = 1'b0;
                    if (deferred_reg) begin
                        deferred_next = 1'b0;
                        notify_next   = 1'b1;
                        nerr_next     = err_v;
                    end
                end

                answer_next  = ans_v;
                m_valid_next = 1'b1;
                state_next   = pac_pkg::ST_OUT;
            end

            // Hold the result beat until it is taken.
            pac_pkg::ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = pac_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = pac_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
